FILE: hw/rtl/fnuc_pkg.sv
// Package: sizes, constants, types and helpers for the farthest-next-use cache
`default_nettype none
package fnuc_pkg;

	localparam int ENTRIES   = 64;
	localparam int TIME_BITS = 32;
	localparam int PRI_BITS  = TIME_BITS + 2;
	localparam int KEY_W     = 64;
	localparam int DIST_W    = 32;
	localparam int CAP_W     = 7;
	localparam int OCC_W     = 7;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int SCAN_W    = IDX_W + 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int WIDE_W    = (CNT_W > CAP_W ? CNT_W : CAP_W) + 1;
	localparam int SUM_W     = (PRI_BITS > DIST_W ? PRI_BITS : DIST_W) + 1;
	localparam int CAP_RESET = 64;

	localparam logic [PRI_BITS-1:0] PRI_NEVER = '1;

	typedef struct packed {
		logic match;
		logic free;
		logic better;
		logic equal;
	} cmp_t;

	// priority = time + distance, or all ones for any negative distance
	function automatic logic [PRI_BITS-1:0] pri_of(input logic [TIME_BITS-1:0] t,
	                                               input logic [DIST_W-1:0] d);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(t) + SUM_W'(d[DIST_W-2:0]);
		if (d[DIST_W-1]) begin
			return PRI_NEVER;
		end
		return sum[PRI_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fnuc_in_if.sv
// Interface: access word channel (key and next-use distance)
`default_nettype none
interface fnuc_in_if;
	logic                                valid;
	logic                                ready;
	logic [fnuc_pkg::KEY_W-1:0]          key;
	logic signed [fnuc_pkg::DIST_W-1:0]  next_distance;

	modport source (output valid, output key, output next_distance, input ready);
	modport sink   (input valid, input key, input next_distance, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fnuc_out_if.sv
// Interface: result word channel (hit, eviction, occupancy)
`default_nettype none
interface fnuc_out_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic                        evicted;
	logic [fnuc_pkg::KEY_W-1:0]  victim_key;
	logic [fnuc_pkg::OCC_W-1:0]  occupancy;

	modport source (output valid, output hit, output evicted, output victim_key,
	                output occupancy, input ready);
	modport sink   (input valid, input hit, input evicted, input victim_key,
	                input occupancy, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fnuc_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module fnuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fnuc_cmp.sv
// Shared compare unit: key match, free slot and farthest-priority test
`default_nettype none
module fnuc_cmp (
	input  logic                          ent_valid,
	input  logic [fnuc_pkg::KEY_W-1:0]    ent_key,
	input  logic [fnuc_pkg::KEY_W-1:0]    ref_key,
	input  logic [fnuc_pkg::PRI_BITS-1:0] ent_pri,
	input  logic [fnuc_pkg::PRI_BITS-1:0] best_pri,
	input  logic                          have_best,
	output fnuc_pkg::cmp_t                res
);

	always_comb begin
		res.match  = ent_valid && (ent_key == ref_key);
		res.free   = !ent_valid;
		res.better = ent_valid && (!have_best || (ent_pri > best_pri));
		res.equal  = (ent_pri == best_pri);
	end

endmodule
`default_nettype wire

FILE: hw/rtl/farthest_next_use_cache.sv
// Top level: fully associative cache with farthest-next-use replacement
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    key, next_distance
//  out_ch   out  valid/ready    hit, evicted, victim_key, occupancy
//  cfg      in   cfg_we         cfg_wdata (capacity)
//
// From accept to result word, every entry is scanned in turn through the shared compare unit,
// then the registered RAM read is awaited and the update is made; the next word is
// accepted in the cycle after the update.
// The update cycle waits while a previous result word is still held in out_ch.
// in_ch is ready only while no access is in progress.
// Reset clears valid bits, count and time at once; no clearing pass.
`default_nettype none
module farthest_next_use_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fnuc_pkg::CAP_W-1:0]    cfg_wdata,
	fnuc_in_if.sink                       in_ch,
	fnuc_out_if.source                    out_ch
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                            state_q;
	logic [fnuc_pkg::KEY_W-1:0]        key_q;
	logic [fnuc_pkg::PRI_BITS-1:0]     pri_q;
	logic [fnuc_pkg::TIME_BITS-1:0]    time_q;
	logic [fnuc_pkg::CNT_W-1:0]        count_q;
	logic [fnuc_pkg::CAP_W-1:0]        cap_q;
	logic [fnuc_pkg::ENTRIES-1:0]      valid_q;
	logic [fnuc_pkg::SCAN_W-1:0]       scan_q;
	logic [fnuc_pkg::IDX_W-1:0]        idx_s1;
	logic                              rd_vld_s1;
	logic                              hit_found_q;
	logic [fnuc_pkg::IDX_W-1:0]        hit_idx_q;
	logic                              free_found_q;
	logic [fnuc_pkg::IDX_W-1:0]        free_idx_q;
	logic                              have_best_q;
	logic [fnuc_pkg::IDX_W-1:0]        best_idx_q;
	logic [fnuc_pkg::PRI_BITS-1:0]     best_pri_q;
	logic [fnuc_pkg::KEY_W-1:0]        best_key_q;

	logic                              out_valid_q;
	logic                              out_hit_q;
	logic                              out_evicted_q;
	logic [fnuc_pkg::KEY_W-1:0]        out_evkey_q;
	logic [fnuc_pkg::OCC_W-1:0]        out_occ_q;

	logic [fnuc_pkg::KEY_W-1:0]        rd_key;
	logic [fnuc_pkg::PRI_BITS-1:0]     rd_pri;

	logic                              op_valid;
	logic [fnuc_pkg::PRI_BITS-1:0]     op_pri;
	fnuc_pkg::cmp_t                    cmp;

	logic                              accept;
	logic                              fire;
	logic                              issuing;
	logic [fnuc_pkg::WIDE_W-1:0]       cap_ext;
	logic [fnuc_pkg::WIDE_W-1:0]       cap_eff;
	logic [fnuc_pkg::WIDE_W-1:0]       count_inc;
	logic                              over;
	logic                              new_best;
	logic                              evict;
	logic [fnuc_pkg::KEY_W-1:0]        ev_key;
	logic                              wr_en;
	logic [fnuc_pkg::IDX_W-1:0]        wr_addr;
	logic                              grow;
	logic [fnuc_pkg::CNT_W-1:0]        count_next;
	logic [fnuc_pkg::ENTRIES-1:0]      valid_next;

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign accept             = in_ch.valid && in_ch.ready;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.hit         = out_hit_q;
	assign out_ch.evicted     = out_evicted_q;
	assign out_ch.victim_key  = out_evkey_q;
	assign out_ch.occupancy   = out_occ_q;

	assign issuing = (scan_q < fnuc_pkg::SCAN_W'(fnuc_pkg::ENTRIES));

	// scan feeds stored entries; the update cycle feeds the new key's priority
	always_comb begin
		if (state_q == ST_FINISH) begin
			op_valid = 1'b1;
			op_pri   = pri_q;
		end else begin
			op_valid = valid_q[idx_s1];
			op_pri   = rd_pri;
		end
	end

	fnuc_cmp u_cmp (
		.ent_valid (op_valid),
		.ent_key   (rd_key),
		.ref_key   (key_q),
		.ent_pri   (op_pri),
		.best_pri  (best_pri_q),
		.have_best (have_best_q),
		.res       (cmp)
	);

	always_comb begin
		cap_ext   = fnuc_pkg::WIDE_W'(cap_q);
		cap_eff   = (cap_ext > fnuc_pkg::WIDE_W'(fnuc_pkg::ENTRIES))
		          ? fnuc_pkg::WIDE_W'(fnuc_pkg::ENTRIES) : cap_ext;
		count_inc = fnuc_pkg::WIDE_W'(count_q) + fnuc_pkg::WIDE_W'(1);
		over      = (count_inc > cap_eff);
		new_best  = cmp.better || (cmp.equal && (free_idx_q < best_idx_q));
		fire      = (state_q == ST_FINISH) && (!out_valid_q || out_ch.ready);
		evict     = !hit_found_q && (!free_found_q || over);
		if (!evict) begin
			ev_key = '0;
		end else if (free_found_q ? new_best : cmp.better) begin
			ev_key = key_q;
		end else begin
			ev_key = best_key_q;
		end
		wr_en = fire && (hit_found_q ||
		        (free_found_q ? (!over || !new_best) : !cmp.better));
		if (hit_found_q) begin
			wr_addr = hit_idx_q;
		end else if (free_found_q) begin
			wr_addr = free_idx_q;
		end else begin
			wr_addr = best_idx_q;
		end
		grow       = !hit_found_q && free_found_q && !over;
		count_next = grow ? count_q + fnuc_pkg::CNT_W'(1) : count_q;
		valid_next = valid_q;
		if (grow) begin
			valid_next[free_idx_q] = 1'b1;
		end else if (!hit_found_q && free_found_q && !new_best) begin
			valid_next[free_idx_q] = 1'b1;
			valid_next[best_idx_q] = 1'b0;
		end
	end

	fnuc_ram #(.WIDTH(fnuc_pkg::KEY_W), .DEPTH(fnuc_pkg::ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (key_q),
		.raddr (scan_q[fnuc_pkg::IDX_W-1:0]),
		.rdata (rd_key)
	);

	fnuc_ram #(.WIDTH(fnuc_pkg::PRI_BITS), .DEPTH(fnuc_pkg::ENTRIES)) u_pri_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (pri_q),
		.raddr (scan_q[fnuc_pkg::IDX_W-1:0]),
		.rdata (rd_pri)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= fnuc_pkg::CAP_W'(fnuc_pkg::CAP_RESET);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			key_q         <= '0;
			pri_q         <= '0;
			time_q        <= '0;
			count_q       <= '0;
			valid_q       <= '0;
			scan_q        <= '0;
			idx_s1        <= '0;
			rd_vld_s1     <= 1'b0;
			hit_found_q   <= 1'b0;
			hit_idx_q     <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			have_best_q   <= 1'b0;
			best_idx_q    <= '0;
			best_pri_q    <= '0;
			best_key_q    <= '0;
			out_valid_q   <= 1'b0;
			out_hit_q     <= 1'b0;
			out_evicted_q <= 1'b0;
			out_evkey_q   <= '0;
			out_occ_q     <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q        <= in_ch.key;
						pri_q        <= fnuc_pkg::pri_of(time_q, in_ch.next_distance);
						scan_q       <= '0;
						rd_vld_s1    <= 1'b0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						have_best_q  <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						scan_q <= scan_q + fnuc_pkg::SCAN_W'(1);
					end
					idx_s1    <= scan_q[fnuc_pkg::IDX_W-1:0];
					rd_vld_s1 <= issuing;
					if (rd_vld_s1) begin
						if (cmp.match && !hit_found_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= idx_s1;
						end
						if (cmp.free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
						if (cmp.better) begin
							have_best_q <= 1'b1;
							best_idx_q  <= idx_s1;
							best_pri_q  <= rd_pri;
							best_key_q  <= rd_key;
						end
						if (idx_s1 == fnuc_pkg::IDX_W'(fnuc_pkg::ENTRIES - 1)) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (fire) begin
						valid_q       <= valid_next;
						count_q       <= count_next;
						time_q        <= time_q + fnuc_pkg::TIME_BITS'(1);
						out_hit_q     <= hit_found_q;
						out_evicted_q <= evict;
						out_evkey_q   <= ev_key;
						out_occ_q     <= fnuc_pkg::OCC_W'(count_next);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fnuc_pkg::CNT_W'($countones(valid_q)) == count_q)
		else $error("entry count differs from number of valid entries");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fnuc_pkg::CNT_W'(fnuc_pkg::ENTRIES))
		else $error("entry count above table size");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && hit_found_q) |=> $stable(count_q) && $stable(valid_q))
		else $error("hit changed occupancy");

	a_result_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result word raised outside update cycle");

	a_no_double_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(hit_found_q && evict))
		else $error("hit flagged with eviction");

endmodule
`default_nettype wire
